// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent holds on the following clock edge.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/skl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key list package
// Field widths, operation and status codes, and the cell control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skl_pkg;

	localparam int OP_W  = 2;
	localparam int ST_W  = 2;
	localparam int CNT_W = 5;
	localparam int KEY_W = 64;
	localparam int CAP_W = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_NEXT   = 2'd2,
		OP_REWIND = 2'd3
	} skl_op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_END       = 2'd3
	} skl_status_t;

	// Per-cell control for one word.
	typedef struct packed {
		logic ins;      // insert accepted and the list is not full
		logic rem;      // remove accepted
		logic occ;      // cell lies below the fill level
		logic at_held;  // cell is the first free slot
	} skl_cell_ctrl_t;

endpackage

// File: hw/rtl/skl_in_if.sv
// ----------------------------------------------------------------------------
// Sorted key list command channel
// Valid/ready channel carrying one operation word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface skl_in_if;
	import skl_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [KEY_W-1:0]   key;

	modport source (output valid, output operation, output key, input ready);
	modport sink (input valid, input operation, input key, output ready);
endinterface

// File: hw/rtl/skl_out_if.sv
// ----------------------------------------------------------------------------
// Sorted key list response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface skl_out_if;
	import skl_pkg::*;

	logic               valid;
	logic               ready;
	logic [ST_W-1:0]    status;
	logic [CNT_W-1:0]   shifted;
	logic [KEY_W-1:0]   value;
	logic [CNT_W-1:0]   count;

	modport source (output valid, output status, output shifted, output value,
		output count, input ready);
	modport sink (input valid, input status, input shifted, input value,
		input count, output ready);
endinterface

// File: hw/rtl/sorted_key_list.sv
// The list accepts one command word per clock cycle and returns its response
// word registered, in the cycle after acceptance; a stalled response holds off
// the next command only while the response register stays full. Every entry
// sits in its own cell, and all cells compare against the key and shift in the
// same cycle, so the cost of one operation is a single wide compare per cell
// followed by the chain that finds the first matching entry.
// ----------------------------------------------------------------------------
// Sorted key list
// Keeps keys in ascending order in a row of cells; supports insert, remove,
// sequential read and rewind of the read cursor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_key_list #(
	parameter int DEPTH    = 16,
	parameter int KEY_BITS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	skl_in_if.sink                   cmd,
	skl_out_if.source                rsp,
	input  logic                     cfg_we,
	input  logic [skl_pkg::CAP_W-1:0] cfg_wdata
);
	import skl_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	logic [CAP_W-1:0]    cap_q;
	logic [CW-1:0]       held_q;
	logic [CNT_W-1:0]    cursor_q;
	logic                out_valid_q;
	logic [ST_W-1:0]     status_q;
	logic [CNT_W-1:0]    shifted_q;
	logic [KEY_W-1:0]    value_q;
	logic [CNT_W-1:0]    count_q;

	logic                acc;
	skl_op_t             op;
	logic [KEY_BITS-1:0] key;
	logic [LW-1:0]       limit;
	logic                full;
	logic                do_ins;
	logic                do_rem;
	logic                found;
	logic                rd_ok;
	logic [IW-1:0]       rd_idx;
	logic [CW-1:0]       ins_pos;
	logic                any_gt;
	logic [CW-1:0]       held_d;
	logic [CNT_W-1:0]    cursor_d;
	logic [ST_W-1:0]     status_d;
	logic [CNT_W-1:0]    shifted_d;
	logic [KEY_W-1:0]    value_d;

	logic [KEY_BITS-1:0] ent [DEPTH];
	logic                gt  [DEPTH];
	logic                fnd [DEPTH];
	skl_cell_ctrl_t      cctl [DEPTH];

	// Handshake: the response register frees up when it is taken.
	assign cmd.ready = !out_valid_q || rsp.ready;
	assign acc       = cmd.valid && cmd.ready;
	assign op        = skl_op_t'(cmd.operation);
	assign key       = cmd.key[KEY_BITS-1:0];

	// Fill limit is the smaller of the capacity register and the built depth.
	always_comb begin
		limit  = (LW'(cap_q) < LW'(DEPTH)) ? LW'(cap_q) : LW'(DEPTH);
		full   = LW'(held_q) >= limit;
		do_ins = acc && (op == OP_INSERT) && !full;
		do_rem = acc && (op == OP_REMOVE);
	end

	// Row of cells.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_BITS-1:0] l_ent;
		logic                l_gt;
		logic [KEY_BITS-1:0] r_ent;
		logic                f_in;

		if (i == 0) begin : g_first
			assign l_ent = '0;
			assign l_gt  = 1'b0;
			assign f_in  = 1'b0;
		end else begin : g_mid
			assign l_ent = ent[i-1];
			assign l_gt  = gt[i-1];
			assign f_in  = fnd[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign r_ent = '0;
		end else begin : g_inner
			assign r_ent = ent[i+1];
		end

		assign cctl[i].ins     = do_ins;
		assign cctl[i].rem     = do_rem;
		assign cctl[i].occ     = CW'(i) < held_q;
		assign cctl[i].at_held = CW'(i) == held_q;

		skl_cell #(
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk         (clk),
			.ctrl        (cctl[i]),
			.key         (key),
			.left_entry  (l_ent),
			.left_gt     (l_gt),
			.right_entry (r_ent),
			.found_in    (f_in),
			.entry       (ent[i]),
			.gt          (gt[i]),
			.found_out   (fnd[i])
		);
	end

	assign found = fnd[DEPTH-1];

	// Insert position: the one cell whose entry is larger while its left
	// neighbour's is not. The larger entries form a run up to the fill level.
	always_comb begin
		ins_pos = '0;
		any_gt  = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			if (gt[i]) begin
				any_gt = 1'b1;
			end
			if (gt[i] && ((i == 0) || !gt[(i == 0) ? 0 : i - 1])) begin
				ins_pos = ins_pos | CW'(i);
			end
		end
	end

	// Read port at the cursor.
	always_comb begin
		rd_ok  = (LW'(cursor_q) < LW'(held_q)) && (LW'(cursor_q) < LW'(DEPTH));
		rd_idx = IW'(cursor_q);
	end

	// Next state and response word.
	always_comb begin
		held_d    = held_q;
		cursor_d  = cursor_q;
		status_d  = ST_OK;
		shifted_d = '0;
		value_d   = '0;
		case (op)
			OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					held_d = held_q + CW'(1);
					if (any_gt) begin
						shifted_d = CNT_W'(held_q - ins_pos);
					end
				end
			end
			OP_REMOVE: begin
				if (found) begin
					held_d = held_q - CW'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			OP_NEXT: begin
				if (rd_ok) begin
					value_d  = KEY_W'(ent[rd_idx]);
					cursor_d = cursor_q + CNT_W'(1);
				end else begin
					status_d = ST_END;
				end
			end
			OP_REWIND: begin
				cursor_d = '0;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			held_q      <= '0;
			cursor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (acc) begin
				held_q      <= held_d;
				cursor_q    <= cursor_d;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Response payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			status_q  <= status_d;
			shifted_q <= shifted_d;
			value_q   <= value_d;
			count_q   <= CNT_W'(held_d);
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.status  = status_q;
	assign rsp.shifted = shifted_q;
	assign rsp.value   = value_q;
	assign rsp.count   = count_q;

	// Checks on the list's own bookkeeping.
	`ASSERT_ALWAYS(a_held_in_range, LW'(held_q) <= LW'(DEPTH))
	`ASSERT_NEXT(a_insert_grows, do_ins, held_q == $past(held_q) + CW'(1))
	`ASSERT_ALWAYS(a_shift_below_count, !out_valid_q || (shifted_q <= count_q))
	`ASSERT_ALWAYS(a_end_reads_zero, !out_valid_q || (status_q != ST_END) || (value_q == '0))

endmodule

// File: hw/rtl/skl_cell.sv
// ----------------------------------------------------------------------------
// Sorted key list cell
// Holds one entry, compares it with the key and trades entries with its
// neighbours when a key is inserted or removed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skl_cell #(
	parameter int KEY_BITS = 64
) (
	input  logic                    clk,
	input  skl_pkg::skl_cell_ctrl_t ctrl,
	input  logic [KEY_BITS-1:0]     key,
	input  logic [KEY_BITS-1:0]     left_entry,
	input  logic                    left_gt,
	input  logic [KEY_BITS-1:0]     right_entry,
	input  logic                    found_in,
	output logic [KEY_BITS-1:0]     entry,
	output logic                    gt,
	output logic                    found_out
);
	import skl_pkg::*;

	logic [KEY_BITS-1:0] entry_q;
	logic                eq;

	// Compare the held entry with the key.
	always_comb begin
		gt        = ctrl.occ && (key < entry_q);
		eq        = ctrl.occ && (key == entry_q);
		found_out = found_in || eq;
	end

	// An insert moves larger entries up one cell and drops the key into the gap;
	// a remove pulls every entry from the first match onwards down one cell.
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_gt) begin
				entry_q <= left_entry;
			end else if (gt || ctrl.at_held) begin
				entry_q <= key;
			end
		end else if (ctrl.rem && found_out) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;

endmodule

// File: test/tb_sorted_key_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key list testbench
// Drives command words into the list over the valid/ready channel and checks
// every response word against a cycle-free model of the ordered list, the
// read cursor and the capacity register. A short directed sequence covers the
// empty list, extreme keys, equal keys, absent keys, reads past the end and a
// full list; random phases then run at several capacities, the extremes among
// them, with random gaps on both channels and some phases at full rate.
// ----------------------------------------------------------------------------

module tb_sorted_key_list;
	import skl_pkg::*;

	localparam int DEPTH       = 16;
	localparam int PLAN_PHASES = 8;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 100;
	// The slowest correct run is about 1230 words.
	localparam int CYCLE_LIMIT = 200000;

	localparam logic [KEY_W-1:0] KEY_APPLE  = 64'h6170_706C_6500_0000;
	localparam logic [KEY_W-1:0] KEY_ABSENT = 64'h0000_0000_0000_1234;
	localparam logic [KEY_W-1:0] KEY_TOP    = 64'h8000_0000_0000_0000;

	// One expected response word.
	typedef struct {
		skl_status_t      status;
		logic [CNT_W-1:0] shifted;
		logic [KEY_W-1:0] value;
		logic [CNT_W-1:0] count;
	} list_reply_t;

	// Model of the list and the queue of response words it predicts.
	class key_list_scoreboard;
		logic [KEY_W-1:0] slots [DEPTH];
		int unsigned      held;
		int unsigned      cursor;
		int unsigned      capacity;
		list_reply_t      replies [$];
		int unsigned      fails;
		int unsigned      matched;

		function new();
			held     = 0;
			cursor   = 0;
			capacity = CAP_RESET;
			fails    = 0;
			matched  = 0;
		endfunction

		task report(string what);
			fails++;
			$display("[%0t] MISMATCH: %s", $time, what);
		endtask

		// Apply one accepted command word and queue the response it causes.
		function void note_command(skl_op_t op, logic [KEY_W-1:0] key);
			list_reply_t w;
			int unsigned lim;
			int unsigned p;
			int unsigned i;
			w.status  = ST_OK;
			w.shifted = '0;
			w.value   = '0;
			lim = (capacity < DEPTH) ? capacity : DEPTH;
			case (op)
				OP_INSERT: begin
					if (held >= lim) begin
						w.status = ST_FULL;
					end else begin
						// Larger entries move up; equal ones stay below the new key.
						p = held;
						while (p > 0 && key < slots[p-1]) begin
							slots[p] = slots[p-1];
							p--;
							w.shifted++;
						end
						slots[p] = key;
						held++;
					end
				end
				OP_REMOVE: begin
					p = 0;
					while (p < held && slots[p] != key)
						p++;
					if (p < held) begin
						for (i = p; i + 1 < held; i++)
							slots[i] = slots[i+1];
						held--;
					end else begin
						w.status = ST_NOT_FOUND;
					end
				end
				OP_NEXT: begin
					// The cursor stays put once it has run past the end.
					if (cursor < held && cursor < DEPTH) begin
						w.value = slots[cursor];
						cursor  = (cursor + 1) & 31;
					end else begin
						w.status = ST_END;
					end
				end
				default: begin
					cursor = 0;
				end
			endcase
			w.count = held[CNT_W-1:0];
			replies.push_back(w);
		endfunction

		// Compare one accepted response word with the oldest expectation.
		task check_response(logic [ST_W-1:0] st, logic [CNT_W-1:0] sh,
			logic [KEY_W-1:0] val, logic [CNT_W-1:0] cnt);
			list_reply_t w;
			if (replies.size() == 0) begin
				report($sformatf("response with none expected: status %0d count %0d",
					st, cnt));
			end else begin
				w = replies.pop_front();
				matched++;
				if (st !== w.status)
					report($sformatf("status %0d, expected %0d", st, w.status));
				if (sh !== w.shifted)
					report($sformatf("shifted %0d, expected %0d", sh, w.shifted));
				if (val !== w.value)
					report($sformatf("value %h, expected %h", val, w.value));
				if (cnt !== w.count)
					report($sformatf("count %0d, expected %0d", cnt, w.count));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	skl_in_if  cmd_if ();
	skl_out_if rsp_if ();

	key_list_scoreboard tally;
	bit               steady;
	int unsigned      issued;
	int unsigned      writes;
	int unsigned      cycles;
	logic [KEY_W-1:0] key_pool [8];
	logic [CAP_W-1:0] cap_plan [PLAN_PHASES] = '{5'd3, 5'd0, 5'd31, 5'd1,
		5'd16, 5'd2, 5'd12, 5'd16};

	sorted_key_list #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_W)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_if),
		.rsp       (rsp_if),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[%0t] run stopped after %0d cycles", $time, cycles);
			$display("Verification failed");
			$finish;
		end
	end

	// Send one command word after a random gap, none in steady phases, and wait until it is taken.
	task automatic issue(skl_op_t op, logic [KEY_W-1:0] key);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_if.valid     <= 1'b1;
		cmd_if.operation <= op;
		cmd_if.key       <= key;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		tally.note_command(op, key);
		issued++;
	endtask

	// Hold off commands until every expected response word has come back.
	task automatic settle();
		cmd_if.valid <= 1'b0;
		while (tally.replies.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] cap);
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		tally.capacity = cap;
		writes++;
	endtask

	// Fresh keys for a phase: random words, packed strings, extremes, repeats.
	task automatic refill_pool();
		int unsigned n;
		int unsigned i;
		int unsigned j;
		for (i = 0; i < 8; i++) begin
			case ($urandom_range(0, 3))
				0: key_pool[i] = {$urandom, $urandom};
				1: begin
					key_pool[i] = '0;
					n = $urandom_range(1, 8);
					for (j = 0; j < n; j++)
						key_pool[i][63 - 8*j -: 8] = 8'h61 + 8'($urandom_range(0, 25));
				end
				2: begin
					case ($urandom_range(0, 3))
						0: key_pool[i] = '0;
						1: key_pool[i] = '1;
						2: key_pool[i] = 64'h1;
						default: key_pool[i] = KEY_TOP;
					endcase
				end
				default: key_pool[i] = key_pool[$urandom_range(0, 7)];
			endcase
		end
	endtask

	// Mostly pooled keys, so that removes hit and equal keys pile up.
	task automatic random_command();
		int unsigned pick;
		logic [KEY_W-1:0] k;
		pick = $urandom_range(0, 99);
		k = {$urandom, $urandom};
		if ($urandom_range(0, 9) < 7)
			k = key_pool[$urandom_range(0, 7)];
		if (pick < 36)
			issue(OP_INSERT, k);
		else if (pick < 66)
			issue(OP_REMOVE, k);
		else if (pick < 90)
			issue(OP_NEXT, {$urandom, $urandom});
		else
			issue(OP_REWIND, {$urandom, $urandom});
	endtask

	// Response side: random stall before each word, none in steady phases, then check it.
	initial begin : reply_sink
		int unsigned stall;
		rsp_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			while (!rsp_if.valid) @(posedge clk);
			tally.check_response(rsp_if.status, rsp_if.shifted, rsp_if.value,
				rsp_if.count);
		end
	end

	initial begin : stimulus
		int p;
		tally            = new();
		cmd_if.valid     = 1'b0;
		cmd_if.operation = OP_INSERT;
		cmd_if.key       = '0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		arst_n           = 1'b0;
		steady           = 1'b0;
		issued           = 0;
		writes           = 0;
		cycles           = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Empty list at the reset capacity.
		issue(OP_NEXT, '1);
		issue(OP_REMOVE, '0);
		// Extreme keys and an equal key.
		issue(OP_INSERT, KEY_APPLE);
		issue(OP_INSERT, '1);
		issue(OP_INSERT, '0);
		issue(OP_INSERT, KEY_TOP);
		issue(OP_INSERT, KEY_APPLE);
		issue(OP_INSERT, 64'h1);
		issue(OP_NEXT, '0);
		issue(OP_NEXT, '0);
		issue(OP_NEXT, '0);
		// Removes, an absent key, and reads running past the shrunk list.
		issue(OP_REMOVE, KEY_APPLE);
		issue(OP_REMOVE, KEY_ABSENT);
		issue(OP_REMOVE, '1);
		issue(OP_NEXT, '0);
		issue(OP_NEXT, '0);
		issue(OP_REMOVE, '0);
		issue(OP_NEXT, '0);
		issue(OP_REWIND, '1);
		issue(OP_NEXT, '0);
		// Fill to the reset capacity, then one insert too many.
		repeat (7) issue(OP_INSERT, {$urandom, $urandom});
		issue(OP_INSERT, KEY_ABSENT);

		// Random phases; the first lowers the capacity below the fill level.
		for (p = 0; p < PHASES; p++) begin
			settle();
			if (p < PLAN_PHASES)
				write_capacity(cap_plan[p]);
			else
				write_capacity(CAP_W'($urandom_range(0, 31)));
			refill_pool();
			steady = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) random_command();
		end
		settle();
		repeat (5) @(posedge clk);

		$display("Covered %0d command words and %0d response words over %0d capacity writes.",
			issued, tally.matched, writes);
		if (tally.fails == 0) begin
			$display("Verification passed");
		end else begin
			$display("%0d mismatches reported.", tally.fails);
			$display("Verification failed");
		end
		$finish;
	end

endmodule
